[src/rrhc_pkg.sv]
// rrhc_pkg: shared types and constants for the ramp-rate heater controller.
// No dependencies.
package rrhc_pkg;

    localparam int PWM_PERIOD_DEF = 500;
    localparam int TICK_W         = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DIV_STEPS      = 16;
    localparam int DIV_CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TEMP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_START = 2'd2;

    localparam logic [6:0] PCT_MAX = 7'd100;

    typedef struct packed {
        logic capture;
        logic ctrl_step;
        logic meas_apply;
        logic pwm_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;

endpackage

[src/rrhc_ctrl.sv]
// rrhc_ctrl: per-word sequencer for the heater controller.
// Depends on rrhc_pkg (cmd_t, sts_t).
module rrhc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  rrhc_pkg::sts_t     sts,
    output rrhc_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTRL,
        ST_DIV,
        ST_MEAS,
        ST_PWM,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.capture    = tick_valid && ready_reg;
        cmd.ctrl_step  = (state_reg == ST_CTRL);
        cmd.meas_apply = (state_reg == ST_MEAS);
        cmd.pwm_step   = (state_reg == ST_PWM);
        cmd.out_load   = (state_reg == ST_OUT) && (!out_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        state_reg <= ST_CTRL;
                        ready_reg <= 1'b0;
                    end
                end
                ST_CTRL:
                begin
                    state_reg <= sts.need_div ? ST_DIV : ST_PWM;
                end
                ST_DIV:
                begin
                    if (sts.div_done)
                        state_reg <= ST_MEAS;
                end
                ST_MEAS:
                begin
                    state_reg <= ST_PWM;
                end
                ST_PWM:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (cmd.out_load)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign tick_ready   = ready_reg;
    assign result_valid = out_valid_reg;

endmodule

[src/rrhc_dp.sv]
// rrhc_dp: ramp controller state, rate divider, PWM machine and result registers.
// Depends on rrhc_pkg (cmd_t, sts_t, constants).
module rrhc_dp #(
    parameter int PWM_PERIOD = rrhc_pkg::PWM_PERIOD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrhc_pkg::cmd_t                    cmd,
    output rrhc_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [rrhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrhc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [15:0]                       seconds_now,
    input  logic                              temp_valid,
    input  logic [11:0]                       temperature,
    input  logic                              reflow_active,
    input  logic                              power_enable,
    output logic                              relay_drive,
    output logic                              temp_wanted,
    output logic                              goal_reached,
    output logic [6:0]                        heat_percent
);

    localparam int TW = rrhc_pkg::TICK_W;

    typedef enum logic [2:0] {
        CP_IDLE    = 3'd0,
        CP_SETUP   = 3'd1,
        CP_ADJUST  = 3'd2,
        CP_WAIT    = 3'd3,
        CP_MEASURE = 3'd4
    } cphase_t;

    typedef enum logic [2:0] {
        PP_IDLE      = 3'd0,
        PP_STANDBY   = 3'd1,
        PP_ON        = 3'd2,
        PP_COUNT_ON  = 3'd3,
        PP_OFF       = 3'd4,
        PP_COUNT_OFF = 3'd5
    } pphase_t;

    // percent -> on-time, built at elaboration
    logic [TW-1:0] tick_lut [0:127];
    for (genvar i = 0; i < 128; i++)
    begin : g_lut
        localparam int Ticks = (i > 90) ? PWM_PERIOD :
                               (i < 10) ? 0 : (i * PWM_PERIOD) / 100;
        assign tick_lut[i] = TW'(Ticks);
    end

    localparam logic [TW-1:0] PERIOD_TICKS = TW'(PWM_PERIOD);

    // configuration
    logic [11:0]        goal_reg;
    logic signed [9:0]  ramp_reg;
    logic [15:0]        seg_reg;

    // model state
    cphase_t            cphase_reg;
    pphase_t            pphase_reg;
    logic [6:0]         pct_reg;
    logic [11:0]        start_reg;
    logic [15:0]        worg_reg;
    logic [TW-1:0]      on_ticks_reg;
    logic [TW-1:0]      latched_reg;
    logic [TW-1:0]      on_cnt_reg;
    logic [TW-1:0]      off_cnt_reg;
    logic               req_reg;
    logic               reached_reg;

    // captured word
    logic [15:0]        now_reg;
    logic               tv_reg;
    logic [11:0]        temp_reg;
    logic               run_reg;

    // divider
    logic               div_busy_reg;
    logic [rrhc_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [15:0]        div_rem_reg;
    logic [15:0]        div_quo_reg;
    logic [15:0]        div_den_reg;
    logic               div_neg_reg;

    // result registers
    logic               relay_drive_reg;
    logic               temp_wanted_reg;
    logic               goal_reached_reg;
    logic [6:0]         heat_percent_reg;

    logic signed [12:0] diff;
    logic [12:0]        diff_mag;
    logic [15:0]        elapsed;
    logic [15:0]        divisor;
    logic [16:0]        rem_sh;
    logic [16:0]        trial;
    logic               ge;
    logic signed [9:0]  rate;
    logic signed [10:0] dlt;
    logic               rising;
    logic               cutoff;
    logic               reach;
    logic [6:0]         pb;
    logic [6:0]         pct_band;
    logic [6:0]         seed;
    logic [15:0]        wait_el;
    logic [TW-1:0]      off_time;

    always_comb
    begin
        diff     = $signed({1'b0, temp_reg}) - $signed({1'b0, start_reg});
        diff_mag = diff[12] ? 13'(-diff) : 13'(diff);
        elapsed  = now_reg - seg_reg;
        divisor  = (elapsed == 16'd0) ? 16'd1 : elapsed;

        rem_sh = {div_rem_reg, div_quo_reg[15]};
        trial  = rem_sh - {1'b0, div_den_reg};
        ge     = (rem_sh >= {1'b0, div_den_reg});

        if (div_neg_reg)
            rate = (div_quo_reg > 16'd512) ? $signed(10'h200) : $signed(~div_quo_reg[9:0] + 10'd1);
        else
            rate = (div_quo_reg > 16'd511) ? 10'sd511 : $signed(div_quo_reg[9:0]);

        dlt    = 11'(rate) - 11'(ramp_reg);
        rising = !ramp_reg[9];
        cutoff = rising && (({1'b0, temp_reg} + 13'd20) >= {1'b0, goal_reg});
        reach  = rising ? (temp_reg >= goal_reg) : (temp_reg <= goal_reg);
        pb     = cutoff ? 7'd0 : pct_reg;

        if (dlt > 11'sd128)
            pct_band = 7'd0;
        else if (dlt > 11'sd64)
            pct_band = (pb >= 7'd30) ? pb - 7'd30 : 7'd0;
        else if (dlt > 11'sd32)
            pct_band = (pb >= 7'd10) ? pb - 7'd10 : 7'd0;
        else if (dlt > -11'sd32)
            pct_band = pb;
        else if (dlt > -11'sd64)
            pct_band = (pb <= 7'd90) ? pb + 7'd10 : rrhc_pkg::PCT_MAX;
        else if (dlt > -11'sd128)
            pct_band = (pb <= 7'd70) ? pb + 7'd30 : rrhc_pkg::PCT_MAX;
        else
            pct_band = rrhc_pkg::PCT_MAX;

        if (ramp_reg[9] || ramp_reg == 10'sd0)
            seed = 7'd0;
        else if (ramp_reg > 10'sd64)
            seed = rrhc_pkg::PCT_MAX;
        else
            seed = 7'(({6'b0, ramp_reg[6:0]} * 13'd100) >> 6);

        wait_el  = now_reg - worg_reg;
        off_time = PERIOD_TICKS - latched_reg;

        sts.need_div = (cphase_reg == CP_MEASURE) && tv_reg;
        sts.div_done = !div_busy_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg  <= seconds_now;
            tv_reg   <= temp_valid;
            temp_reg <= temperature;
            run_reg  <= reflow_active && power_enable;
        end
        if (cmd.ctrl_step && sts.need_div)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= {diff_mag[11:0], 4'b0000};
            div_den_reg <= divisor;
            div_neg_reg <= diff[12];
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= ge ? trial[15:0] : rem_sh[15:0];
            div_quo_reg <= {div_quo_reg[14:0], ge};
        end
        if (cmd.out_load)
        begin
            relay_drive_reg  <= (pphase_reg == PP_COUNT_ON) || (pphase_reg == PP_OFF);
            temp_wanted_reg  <= req_reg;
            goal_reached_reg <= reached_reg;
            heat_percent_reg <= pct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg     <= '0;
            ramp_reg     <= '0;
            seg_reg      <= '0;
            cphase_reg   <= CP_IDLE;
            pphase_reg   <= PP_IDLE;
            pct_reg      <= '0;
            start_reg    <= '0;
            worg_reg     <= '0;
            on_ticks_reg <= '0;
            latched_reg  <= '0;
            on_cnt_reg   <= '0;
            off_cnt_reg  <= '0;
            req_reg      <= 1'b0;
            reached_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rrhc_pkg::CFG_GOAL_TEMP:     goal_reg <= cfg_data[11:0];
                    rrhc_pkg::CFG_RAMP_RATE:     ramp_reg <= $signed(cfg_data[9:0]);
                    rrhc_pkg::CFG_SEGMENT_START:
                    begin
                        seg_reg     <= cfg_data;
                        reached_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            // rate divider, one quotient bit per cycle
            if (cmd.ctrl_step && sts.need_div)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == rrhc_pkg::DIV_CNT_W'(rrhc_pkg::DIV_STEPS - 1))
                    div_busy_reg <= 1'b0;
            end

            if (cmd.ctrl_step && !sts.need_div)
            begin
                case (cphase_reg)
                    CP_SETUP:
                    begin
                        req_reg <= 1'b1;
                        if (tv_reg)
                        begin
                            req_reg    <= 1'b0;
                            start_reg  <= temp_reg;
                            pct_reg    <= seed;
                            cphase_reg <= CP_ADJUST;
                        end
                    end
                    CP_ADJUST:
                    begin
                        on_ticks_reg <= tick_lut[pct_reg];
                        worg_reg     <= now_reg;
                        cphase_reg   <= CP_WAIT;
                    end
                    CP_WAIT:
                    begin
                        if (wait_el >= 16'd2)
                            cphase_reg <= CP_MEASURE;
                    end
                    CP_MEASURE:
                    begin
                        req_reg <= 1'b1;
                    end
                    default:
                    begin
                        on_ticks_reg <= '0;
                        cphase_reg   <= (goal_reg != 12'd0 && ramp_reg != 10'sd0) ?
                                        CP_SETUP : CP_IDLE;
                    end
                endcase
            end

            if (cmd.meas_apply)
            begin
                req_reg <= 1'b0;
                if (reach)
                begin
                    pct_reg     <= '0;
                    reached_reg <= 1'b1;
                    cphase_reg  <= CP_IDLE;
                end
                else
                begin
                    pct_reg    <= pct_band;
                    cphase_reg <= CP_ADJUST;
                end
            end

            if (cmd.pwm_step)
            begin
                case (pphase_reg)
                    PP_STANDBY:
                    begin
                        if (run_reg && on_ticks_reg != '0)
                        begin
                            latched_reg <= on_ticks_reg;
                            pphase_reg  <= PP_ON;
                        end
                        else
                            pphase_reg <= PP_IDLE;
                    end
                    PP_ON:
                    begin
                        pphase_reg <= PP_COUNT_ON;
                    end
                    PP_COUNT_ON:
                    begin
                        if (on_cnt_reg == latched_reg)
                        begin
                            on_cnt_reg <= '0;
                            pphase_reg <= PP_OFF;
                        end
                        else
                            on_cnt_reg <= on_cnt_reg + 1'b1;
                    end
                    PP_OFF:
                    begin
                        pphase_reg <= PP_COUNT_OFF;
                    end
                    PP_COUNT_OFF:
                    begin
                        if (off_cnt_reg == off_time)
                        begin
                            off_cnt_reg <= '0;
                            pphase_reg  <= PP_STANDBY;
                        end
                        else
                            off_cnt_reg <= off_cnt_reg + 1'b1;
                    end
                    default:
                    begin
                        pphase_reg <= run_reg ? PP_STANDBY : PP_IDLE;
                    end
                endcase
            end
        end
    end

    assign relay_drive  = relay_drive_reg;
    assign temp_wanted  = temp_wanted_reg;
    assign goal_reached = goal_reached_reg;
    assign heat_percent = heat_percent_reg;

endmodule

[src/ramp_rate_heater_controller_unit.sv]
// ramp_rate_heater_controller_unit: top level, sequencer plus datapath.
// Depends on rrhc_pkg, rrhc_ctrl, rrhc_dp.
//
// One input word is one 2 ms tick (seconds_now, temp_valid, temperature,
// reflow_active, power_enable) on tick_valid/tick_ready. Each word steps
// the ramp controller and then the 500-tick heater PWM and yields exactly
// one result word (relay_drive, temp_wanted, goal_reached, heat_percent) on
// result_valid/result_ready.
// A result passes the sequencer states CTRL, PWM and OUT and is then
// registered; a word that carries a temperature while the controller
// measures rate also passes DIV, held by the 16-step restoring divider
// (one quotient bit per cycle), and MEAS, which hands its quotient back.
// The unit takes one word at a time; tick_ready returns as the result is
// loaded, so the next word is taken while a result still waits. When
// the receiver stalls, a finished word waits in the sequencer's last
// step until the output register frees.
// Configuration: cfg_we writes register cfg_index (0 goal_temp,
// 1 ramp_rate, 2 segment_start) from cfg_data; the user must write only
// while idle, which the block does not enforce. Reset zeroes control
// state and config, not data or result registers; no clearing pass.
module ramp_rate_heater_controller_unit #(
    parameter int PWM_PERIOD = rrhc_pkg::PWM_PERIOD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_valid,
    output logic                              tick_ready,
    input  logic [15:0]                       seconds_now,
    input  logic                              temp_valid,
    input  logic [11:0]                       temperature,
    input  logic                              reflow_active,
    input  logic                              power_enable,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              relay_drive,
    output logic                              temp_wanted,
    output logic                              goal_reached,
    output logic [6:0]                        heat_percent,
    input  logic                              cfg_we,
    input  logic [rrhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrhc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rrhc_pkg::cmd_t cmd;
    rrhc_pkg::sts_t sts;

    rrhc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    rrhc_dp #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .seconds_now    (seconds_now),
        .temp_valid     (temp_valid),
        .temperature    (temperature),
        .reflow_active  (reflow_active),
        .power_enable   (power_enable),
        .relay_drive    (relay_drive),
        .temp_wanted    (temp_wanted),
        .goal_reached   (goal_reached),
        .heat_percent   (heat_percent)
    );

endmodule

[src/rrhc_checker.sv]
// rrhc_checker: port-level checks for the heater controller, bound to the top.
// Depends on ramp_rate_heater_controller_unit port names.
module rrhc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic       temp_wanted,
    input logic       goal_reached,
    input logic [6:0] heat_percent
);

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (heat_percent <= 7'd100))
        else $error("heat_percent above 100");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> !tick_ready)
        else $error("second word accepted while busy");

    a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable({temp_wanted, goal_reached}))
        else $error("stalled result flags changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(heat_percent)))
        else $error("stalled result changed");

endmodule

bind ramp_rate_heater_controller_unit rrhc_checker u_rrhc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .temp_wanted  (temp_wanted),
    .goal_reached (goal_reached),
    .heat_percent (heat_percent)
);
